### rtl/sle_pkg.sv
// Shared definitions for the sequential list engine.
// Holds request and status codes, port widths and the controller/datapath interface structs.
// No dependencies.
package sle_pkg;

  // Fixed port widths
  localparam int OP_W    = 3;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int CNTO_W  = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_REM_END   = 3'd4;
  localparam logic [OP_W-1:0] OP_REM_POS   = 3'd5;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture request, check it, set up pointers
    logic rd;     // read memory at the pointer
    logic mv;     // write read data one place over, step pointer
    logic grab;   // keep read data as the removed word, step pointer
    logic put;    // write new word at target, count up
    logic drop;   // count down after a removal
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ok_ins;    // insert request passed its checks
    logic ok_rem;    // remove request passed its checks
    logic no_shift;  // insert target equals count
    logic ins_last;  // insert shift reached the target
    logic rem_last;  // remove shift reached the end of the list
  } dp_stat_t;

endpackage

### rtl/sle_datapath.sv
// Datapath of the sequential list engine: list memory, count, pointers and result registers.
// Driven by commands from sle_ctrl; depends on sle_pkg.
module sle_datapath #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sle_pkg::dp_cmd_t            cmd,
  output sle_pkg::dp_stat_t           stat,
  input  logic [sle_pkg::OP_W-1:0]    op,
  input  logic [sle_pkg::POS_W-1:0]   position,
  input  logic [sle_pkg::VAL_W-1:0]   entry_value,
  output logic [sle_pkg::VAL_W-1:0]   removed_value,
  output logic [sle_pkg::ST_W-1:0]    status,
  output logic [sle_pkg::CNTO_W-1:0]  count
);
  import sle_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] removed;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      where;
  logic [CNT_W-1:0]      ptr;
  logic [ST_W-1:0]       status_r;
  logic                  ins_mode;
  logic                  ok_ins;
  logic                  ok_rem;

  // Request checks
  logic [CMP_W-1:0]      pos_w;
  logic [CMP_W-1:0]      cnt_w;
  logic [CMP_W-1:0]      where_sel;
  logic [ST_W-1:0]       status_calc;
  logic                  ins_req;
  logic                  ins_ok_calc;
  logic                  rem_ok_calc;
  logic [CNT_W-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [63:0]           word_ext;

  assign pos_w    = CMP_W'(position);
  assign cnt_w    = CMP_W'(count_r);
  assign word_ext = 64'(entry_value);

  always_comb begin
    where_sel   = '0;
    status_calc = ST_OK;
    ins_req     = 1'b0;
    ins_ok_calc = 1'b0;
    rem_ok_calc = 1'b0;
    case (op)
      OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
        ins_req = 1'b1;
        if (op == OP_INS_FRONT) where_sel = '0;
        else if (op == OP_INS_END) where_sel = cnt_w;
        else where_sel = pos_w;
        if (count_r >= CNT_W'(DEPTH)) status_calc = ST_FULL;
        else if (where_sel > cnt_w) status_calc = ST_RANGE;
        else ins_ok_calc = 1'b1;
      end
      OP_REM_FRONT, OP_REM_END, OP_REM_POS: begin
        if (op == OP_REM_FRONT) where_sel = '0;
        else if (op == OP_REM_END) where_sel = cnt_w - 1'b1;
        else where_sel = pos_w;
        if (count_r == '0) status_calc = ST_EMPTY;
        else if (where_sel >= cnt_w) status_calc = ST_RANGE;
        else rem_ok_calc = 1'b1;
      end
      default: begin
        status_calc = ST_OK;
      end
    endcase
  end

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_r <= '0;
    end else begin
      if (cmd.put) count_r <= count_r + 1'b1;
      else if (cmd.drop) count_r <= count_r - 1'b1;
    end
  end

  // Request, pointer and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word     <= word_ext[DATA_WIDTH-1:0];
      where    <= CNT_W'(where_sel);
      status_r <= status_calc;
      ins_mode <= ins_req;
      ok_ins   <= ins_ok_calc;
      ok_rem   <= rem_ok_calc;
      removed  <= '0;
      ptr      <= ins_req ? (count_r - 1'b1) : CNT_W'(where_sel);
    end
    if (cmd.mv) ptr <= ins_mode ? (ptr - 1'b1) : (ptr + 1'b1);
    if (cmd.grab) begin
      removed <= rdata;
      ptr     <= ptr + 1'b1;
    end
  end

  // Memory write address and data
  always_comb begin
    if (cmd.put) begin
      wr_addr = where;
      wr_data = word;
    end else begin
      wr_addr = ins_mode ? (ptr + 1'b1) : (ptr - 1'b1);
      wr_data = rdata;
    end
  end

  // List storage
  always_ff @(posedge clk) begin
    if (cmd.mv || cmd.put) mem[wr_addr[AW-1:0]] <= wr_data;
    if (cmd.rd) rdata <= mem[ptr[AW-1:0]];
  end

  assign stat.ok_ins   = ok_ins;
  assign stat.ok_rem   = ok_rem;
  assign stat.no_shift = (where == count_r);
  assign stat.ins_last = (ptr == where);
  assign stat.rem_last = (CNT_W'(ptr + 1'b1) == count_r);

  assign removed_value = VAL_W'(removed);
  assign status        = status_r;
  assign count         = CNTO_W'(count_r);

endmodule

### rtl/sle_ctrl.sv
// Controller of the sequential list engine: sequences the shift loop and the handshakes.
// Issues commands to sle_datapath; depends on sle_pkg.
module sle_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output sle_pkg::dp_cmd_t   cmd,
  input  sle_pkg::dp_stat_t  stat
);
  import sle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_READ0,
    S_GRAB,
    S_READ,
    S_MOVE,
    S_PUT,
    S_DROP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.ok_ins) state_next = stat.no_shift ? S_PUT : S_READ;
        else if (stat.ok_rem) state_next = S_READ0;
        else state_next = S_DONE;
      end
      S_READ0: begin
        cmd.rd     = 1'b1;
        state_next = S_GRAB;
      end
      S_GRAB: begin
        cmd.grab   = 1'b1;
        state_next = stat.rem_last ? S_DROP : S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_MOVE;
      end
      S_MOVE: begin
        cmd.mv = 1'b1;
        if (stat.ok_ins) state_next = stat.ins_last ? S_PUT : S_READ;
        else state_next = stat.rem_last ? S_DROP : S_READ;
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_DONE;
      end
      S_DROP: begin
        cmd.drop   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_stall  <= (state_next != S_IDLE);
      out_valid <= (state_next == S_DONE);
    end
  end

endmodule

### rtl/sequential_list_engine_core.sv
// Sequential list engine: an ordered list of up to DEPTH words with insert and remove requests.
// Top level; instantiates sle_ctrl and sle_datapath, depends on sle_pkg.
//
// Usage:
//   Request channel: in_valid/in_stall with op, position, entry_value. A request is taken
//   on a clock edge with in_valid high and in_stall low. One request is worked at a time.
//   Result channel: out_valid/out_stall with removed_value, status, count; one result per
//   request, held stable while out_stall is high.
// Shift: a rejected request or unused op moves no entries; an insert moves the
//   k = count - target entries at and after the target, a remove the k = count - target - 1
//   entries after it. Each moved entry is read from the list memory and then written
//   one place over; no read and write of the memory fall in the same cycle.
//   in_stall drops at the edge that takes the result.
// Reset: rst is synchronous. It empties the list (count zero); in_stall is high during
//   reset and drops the cycle after. Memory contents need no clearing.
// Receiver stall: the result stays on the ports and no new request is taken.
module sequential_list_engine_core #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sle_pkg::OP_W-1:0]    op,
  input  logic [sle_pkg::POS_W-1:0]   position,
  input  logic [sle_pkg::VAL_W-1:0]   entry_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sle_pkg::VAL_W-1:0]   removed_value,
  output logic [sle_pkg::ST_W-1:0]    status,
  output logic [sle_pkg::CNTO_W-1:0]  count
);
  import sle_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Storage and result registers
  sle_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (op),
    .position      (position),
    .entry_value   (entry_value),
    .removed_value (removed_value),
    .status        (status),
    .count         (count)
  );

endmodule

### rtl/sle_checker.sv
// Port-level checks for the sequential list engine, bound to the top level.
// Depends on sle_pkg and sequential_list_engine_core.
module sle_checker #(
  parameter int DEPTH = 64
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [sle_pkg::VAL_W-1:0]   removed_value,
  input logic [sle_pkg::ST_W-1:0]    status,
  input logic [sle_pkg::CNTO_W-1:0]  count
);
  import sle_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(removed_value) && $stable(status)
      && $stable(count))
    else $error("result changed while stalled");

  // One request in flight: the input side closes right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  // Failed requests return no data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> removed_value == '0)
    else $error("failed request returned data");

  // Empty error only with an empty list
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> count == '0)
    else $error("empty status with entries present");

  // Full error only with a full list
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> count == CNTO_W'(DEPTH))
    else $error("full status with room left");

endmodule

bind sequential_list_engine_core sle_checker #(.DEPTH(DEPTH)) u_sle_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .removed_value (removed_value),
  .status        (status),
  .count         (count)
);
